### sv/scgc_pkg.sv
package scgc_pkg;

   localparam int unsigned MAX_DEGREE_DEFAULT = 32;

   localparam int unsigned POLY_W     = 32;
   localparam int unsigned DEG_W      = 6;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [POLY_W-1:0] POLY_RESET = 32'h04C1_1DB7;
   localparam logic [DEG_W-1:0]  DEG_RESET  = 6'd32;

   typedef enum logic {
      MODE_GENERATE = 1'b0,
      MODE_CHECK    = 1'b1
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POLY   = 2'd0,
      CSR_DEGREE = 2'd1,
      CSR_MODE   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic data_bit;
      logic last_in;
   } req_type;

   typedef struct packed {
      logic crc_bit;
      logic error;
      logic last_out;
   } rsp_type;

endpackage

### sv/scgc_front.sv
module scgc_front #(
   parameter int unsigned MAX_DEGREE = scgc_pkg::MAX_DEGREE_DEFAULT,
   localparam int unsigned DW = $clog2(MAX_DEGREE + 1),
   localparam int unsigned JW = MAX_DEGREE + DW + 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [scgc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [scgc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  scgc_pkg::req_type                req_data,
   output logic                             push_valid,
   input  logic                             push_ready,
   output logic [JW-1:0]                    push_data
);
   import scgc_pkg::*;

   localparam int unsigned IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
   localparam logic [6:0]  MAX_DEG7 = 7'(MAX_DEGREE);

   logic [POLY_W-1:0]     poly_ff, poly_in;
   logic [DEG_W-1:0]      deg_ff, deg_in;
   mode_type              mode_ff, mode_in;
   logic [MAX_DEGREE-1:0] rem_ff, rem_in;

   logic [DW-1:0]         eff_deg;
   logic [IW-1:0]         top_idx;
   logic [MAX_DEGREE-1:0] mask;
   logic [MAX_DEGREE-1:0] poly_ext;
   logic [MAX_DEGREE-1:0] poly_m;
   logic [MAX_DEGREE-1:0] rem_m;
   logic [MAX_DEGREE-1:0] rem_next;
   logic                  top_bit;
   logic                  accept;

   always_comb begin
      poly_in = poly_ff;
      deg_in  = deg_ff;
      mode_in = mode_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_POLY: begin
               poly_in = csr_wdata[POLY_W-1:0];
            end
            CSR_DEGREE: begin
               deg_in = csr_wdata[DEG_W-1:0];
            end
            CSR_MODE: begin
               mode_in = mode_type'(csr_wdata[0]);
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (deg_ff == '0) begin
         eff_deg = DW'(1);
      end else if ({1'b0, deg_ff} > MAX_DEG7) begin
         eff_deg = DW'(MAX_DEGREE);
      end else begin
         eff_deg = DW'(deg_ff);
      end
   end

   assign top_idx = IW'(eff_deg - DW'(1));

   always_comb begin
      for (int i = 0; i < MAX_DEGREE; i++) begin
         mask[i] = (i < int'(eff_deg));
      end
   end

   generate
      if (MAX_DEGREE > POLY_W) begin : g_poly_wide
         assign poly_ext = {{(MAX_DEGREE - POLY_W){1'b0}}, poly_ff};
      end else if (MAX_DEGREE == POLY_W) begin : g_poly_same
         assign poly_ext = poly_ff;
      end else begin : g_poly_narrow
         assign poly_ext = poly_ff[MAX_DEGREE-1:0];
      end
   endgenerate

   assign poly_m  = poly_ext & mask;
   assign rem_m   = rem_ff & mask;
   assign top_bit = rem_m[top_idx];

   always_comb begin
      if (mode_ff == MODE_CHECK) begin
         rem_next = (((rem_m << 1) | MAX_DEGREE'(req_data.data_bit)) & mask)
                    ^ (top_bit ? poly_m : '0);
      end else begin
         rem_next = ((rem_m << 1) & mask)
                    ^ ((top_bit ^ req_data.data_bit) ? poly_m : '0);
      end
   end

   assign req_stall = !push_ready;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      rem_in = rem_ff;
      if (accept) begin
         rem_in = req_data.last_in ? '0 : rem_next;
      end
   end

   assign push_valid = accept && req_data.last_in;
   assign push_data  = {mode_ff, eff_deg, rem_next};

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= POLY_RESET;
         deg_ff  <= DEG_RESET;
         mode_ff <= MODE_GENERATE;
         rem_ff  <= '0;
      end else begin
         poly_ff <= poly_in;
         deg_ff  <= deg_in;
         mode_ff <= mode_in;
         rem_ff  <= rem_in;
      end
   end

`ifndef ASSERT_OFF
   a_rem_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.last_in |=> rem_ff == '0)
      else $error("remainder not cleared after final item");
`endif

endmodule

### sv/scgc_queue.sv
module scgc_queue #(
   parameter int unsigned WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int unsigned DEPTH = 2;
   localparam int unsigned PW    = $clog2(DEPTH);
   localparam int unsigned CW    = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem[rd_ptr_ff];

   assign push = push_valid && push_ready;
   assign pop  = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> push_ready)
      else $error("item pushed into full queue");
`endif

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count out of range");
`endif

endmodule

### sv/scgc_back.sv
module scgc_back #(
   parameter int unsigned MAX_DEGREE = scgc_pkg::MAX_DEGREE_DEFAULT,
   localparam int unsigned DW = $clog2(MAX_DEGREE + 1),
   localparam int unsigned JW = MAX_DEGREE + DW + 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  logic [JW-1:0]     pop_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output scgc_pkg::rsp_type rsp_data
);
   import scgc_pkg::*;

   localparam int unsigned IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

   logic                  busy_ff, busy_in;
   mode_type              mode_ff, mode_in;
   logic [DW-1:0]         cnt_ff, cnt_in;
   logic [MAX_DEGREE-1:0] sh_ff, sh_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  emit;
   logic [IW-1:0]         bit_idx;

   assign pop_ready = !busy_ff;
   assign emit      = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign bit_idx   = IW'(cnt_ff - DW'(1));

   always_comb begin
      busy_in      = busy_ff;
      mode_in      = mode_ff;
      cnt_in       = cnt_ff;
      sh_in        = sh_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (pop_valid && !busy_ff) begin
         busy_in = 1'b1;
         mode_in = mode_type'(pop_data[JW-1]);
         cnt_in  = pop_data[JW-2:MAX_DEGREE];
         sh_in   = pop_data[MAX_DEGREE-1:0];
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (mode_ff == MODE_CHECK) begin
            rsp_in.crc_bit  = 1'b0;
            rsp_in.error    = |sh_ff;
            rsp_in.last_out = 1'b1;
            busy_in         = 1'b0;
         end else begin
            rsp_in.crc_bit  = sh_ff[bit_idx];
            rsp_in.error    = 1'b0;
            rsp_in.last_out = (cnt_ff == DW'(1));
            cnt_in          = cnt_ff - DW'(1);
            busy_in         = (cnt_ff != DW'(1));
         end
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      cnt_ff  <= cnt_in;
      sh_ff   <= sh_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.error |-> rsp_ff.last_out)
      else $error("error flag on item that is not final");
`endif

`ifndef ASSERT_OFF
   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      emit && mode_ff == MODE_GENERATE && cnt_ff == DW'(1) |=> !busy_ff)
      else $error("serialiser still busy after final bit");
`endif

`ifndef ASSERT_OFF
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      busy_ff && rsp_valid_ff && rsp_stall |=> $stable(cnt_ff))
      else $error("bit count advanced while output stalled");
`endif

endmodule

### sv/serial_crc_generate_check.sv
// Bit-serial CRC generator and checker with a programmable polynomial (implicit leading one,
// no initial value, reflection or final xor). The input side takes one message bit per cycle,
// most significant first, and updates the remainder in a single xor level; it stalls only when
// the two-entry job queue is full. A final bit pushes the remainder, degree and mode into the
// queue and clears the remainder, so the next message may start in the following cycle.
// The output side pops one job, loads it into its shift register, then emits one item per
// cycle while the output is not stalled: degree remainder bits in generate mode, a single
// error flag in check mode; the next job is popped only after the last item, so the
// serialiser bounds the sustained message rate. Write configuration only while idle.
module serial_crc_generate_check #(
   parameter int unsigned MAX_DEGREE = scgc_pkg::MAX_DEGREE_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [scgc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [scgc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  scgc_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output scgc_pkg::rsp_type                rsp_data
);
   import scgc_pkg::*;

   localparam int unsigned DW = $clog2(MAX_DEGREE + 1);
   localparam int unsigned JW = MAX_DEGREE + DW + 1;

   logic          push_valid;
   logic          push_ready;
   logic [JW-1:0] push_data;
   logic          pop_valid;
   logic          pop_ready;
   logic [JW-1:0] pop_data;

   scgc_front #(
      .MAX_DEGREE (MAX_DEGREE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   scgc_queue #(
      .WIDTH (JW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   scgc_back #(
      .MAX_DEGREE (MAX_DEGREE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
